/* sv/uds_pkg.sv */
// shared types, constants and decode helpers for the utf-8 stream decoder
package uds_pkg;

  // width of the running unit counter; the reported count is its low 32 bits
  localparam int unsigned CountBits = 32;
  localparam int unsigned MaxUnits  = 4;
  // a lead plus at most two continuations are ever held between beats
  localparam int unsigned HeldDepth = 3;
  localparam int unsigned HeldIdxW  = $clog2(HeldDepth);
  localparam int unsigned JobQDepth = 2;
  localparam int unsigned JobQPtrW  = (JobQDepth > 1) ? $clog2(JobQDepth) : 1;
  localparam int unsigned JobQCntW  = $clog2(JobQDepth + 1);

  localparam logic [20:0] MinTwo    = 21'h000080;
  localparam logic [20:0] MinThree  = 21'h000800;
  localparam logic [20:0] MinFour   = 21'h010000;
  localparam logic [20:0] MaxScalar = 21'h10FFFF;
  localparam logic [20:0] SurrLo    = 21'h00D800;
  localparam logic [20:0] SurrHi    = 21'h00DFFF;

  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;
  localparam logic [2:0] LenNone  = 3'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  unit_length;
    logic        is_error;
    logic [31:0] unit_count;
    logic        last_of_run;
    logic        text_done;
  } out_beat_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  unit_length;
    logic        is_error;
  } unit_t;

  // all units caused by one input beat
  typedef struct packed {
    unit_t [MaxUnits-1:0] units;
    logic [2:0]           num_units;
    logic                 end_of_text;
  } job_t;

  // sequence length of a multi-byte lead, zero otherwise
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7:5] == 3'b110) begin
      len = LenTwo;
    end else if (b[7:4] == 4'b1110) begin
      len = LenThree;
    end else if (b[7:3] == 5'b11110) begin
      len = LenFour;
    end else begin
      len = LenNone;
    end
    return len;
  endfunction

  function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] need);
    logic [20:0] cp;
    unique case (need)
      LenTwo:   cp = {10'd0, b0[4:0], b1[5:0]};
      LenThree: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      LenFour:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:  cp = '0;
    endcase
    return cp;
  endfunction

  // rejects overlong forms, surrogates and values past the last scalar
  function automatic logic scalar_ok(input logic [20:0] cp, input logic [2:0] need);
    logic [20:0] minimum;
    unique case (need)
      LenTwo:   minimum = MinTwo;
      LenThree: minimum = MinThree;
      default:  minimum = MinFour;
    endcase
    return (cp >= minimum) && (cp <= MaxScalar) && !((cp >= SurrLo) && (cp <= SurrHi));
  endfunction

endpackage

/* sv/uds_front.sv */
// front end: takes bytes, tracks the open sequence and builds at most one job per byte
module uds_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  uds_pkg::in_beat_t in_data_i,
  output logic              job_valid_o,
  output uds_pkg::job_t     job_o,
  input  logic              job_full_i
);

  logic [7:0]                   held_q [uds_pkg::HeldDepth];
  logic [uds_pkg::HeldIdxW-1:0] held_cnt_q, held_cnt_d;

  logic [7:0]    b;
  logic          eot;
  logic          accept;
  logic [7:0]    seq [uds_pkg::MaxUnits];
  logic [2:0]    need, newc, flush_n, num;
  logic [20:0]   cp;
  logic          cp_ok;
  logic          do_fresh, single_ok, hold_cont, fresh_hold, fresh_emit, ascii;
  uds_pkg::job_t job;

  assign b      = in_data_i.data_byte;
  assign eot    = in_data_i.end_of_text;
  assign accept = in_valid_i & ~job_full_i;

  // held bytes first, the incoming byte right after them
  always_comb begin
    for (int i = 0; i < int'(uds_pkg::MaxUnits); i++) begin
      seq[i] = b;
    end
    for (int i = 0; i < int'(uds_pkg::HeldDepth); i++) begin
      if (3'(i) < {1'b0, held_cnt_q}) begin
        seq[i] = held_q[i];
      end
    end
  end

  always_comb begin
    need       = uds_pkg::seq_len(held_q[0]);
    newc       = {1'b0, held_cnt_q} + 3'd1;
    cp         = uds_pkg::assemble(seq[0], seq[1], seq[2], seq[3], need);
    cp_ok      = uds_pkg::scalar_ok(cp, need);
    flush_n    = '0;
    do_fresh   = 1'b0;
    single_ok  = 1'b0;
    hold_cont  = 1'b0;

    if (held_cnt_q == '0) begin
      do_fresh = 1'b1;
    end else if (b[7:6] == 2'b10) begin
      if (newc == need) begin
        if (cp_ok) begin
          single_ok = 1'b1;
        end else begin
          flush_n = newc;
        end
      end else if (eot) begin
        flush_n = newc;
      end else begin
        hold_cont = 1'b1;
      end
    end else begin
      // stray non-continuation: dump held bytes, then decode it afresh
      flush_n  = {1'b0, held_cnt_q};
      do_fresh = 1'b1;
    end

    ascii      = ~b[7];
    fresh_hold = do_fresh & ~ascii & (uds_pkg::seq_len(b) != uds_pkg::LenNone) & ~eot;
    fresh_emit = do_fresh & ~fresh_hold;

    job = '0;
    for (int i = 0; i < int'(uds_pkg::MaxUnits); i++) begin
      if (single_ok && (i == 0)) begin
        job.units[i] = '{code_point: cp, unit_length: need, is_error: 1'b0};
      end else if (3'(i) < flush_n) begin
        job.units[i] = '{code_point: 21'(seq[i]), unit_length: uds_pkg::LenOne,
                         is_error: 1'b1};
      end else if (fresh_emit && (3'(i) == flush_n)) begin
        job.units[i] = '{code_point: 21'(b), unit_length: uds_pkg::LenOne,
                         is_error: ~ascii};
      end
    end
    num = single_ok ? 3'd1 : (flush_n + {2'd0, fresh_emit});
    job.num_units   = num;
    job.end_of_text = eot;

    if (eot) begin
      held_cnt_d = '0;
    end else if (hold_cont) begin
      held_cnt_d = newc[uds_pkg::HeldIdxW-1:0];
    end else if (fresh_hold) begin
      held_cnt_d = uds_pkg::HeldIdxW'(1);
    end else begin
      held_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= '0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < int'(uds_pkg::HeldDepth); i++) begin
        if ((hold_cont && (uds_pkg::HeldIdxW'(i) == held_cnt_q)) ||
            (fresh_hold && (i == 0))) begin
          held_q[i] <= b;
        end
      end
    end
  end

  assign in_stall_o  = job_full_i;
  assign job_valid_o = accept & (num != '0);
  assign job_o       = job;

endmodule

/* sv/uds_job_fifo.sv */
// short job queue between the front end and the unit emitter
module uds_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uds_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output uds_pkg::job_t head_o
);

  uds_pkg::job_t                 mem_q [uds_pkg::JobQDepth];
  logic [uds_pkg::JobQPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [uds_pkg::JobQCntW-1:0]  cnt_q;

  function automatic logic [uds_pkg::JobQPtrW-1:0] ptr_next(
      input logic [uds_pkg::JobQPtrW-1:0] p);
    logic [uds_pkg::JobQPtrW-1:0] n;
    if (p == uds_pkg::JobQPtrW'(uds_pkg::JobQDepth - 1)) begin
      n = '0;
    end else begin
      n = p + uds_pkg::JobQPtrW'(1);
    end
    return n;
  endfunction

  assign full_o       = (cnt_q == uds_pkg::JobQCntW'(uds_pkg::JobQDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + uds_pkg::JobQCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - uds_pkg::JobQCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/uds_back.sv */
// back end: walks each job one unit per cycle unless stalled, counts units, owns the output register
module uds_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  uds_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uds_pkg::out_beat_t out_data_o
);

  logic [1:0]                  idx_q, idx_d;
  logic [uds_pkg::CountBits-1:0] cnt_q, cnt_d, cnt_inc;
  logic                        out_valid_q, out_valid_d;
  uds_pkg::out_beat_t          out_q, out_d;
  logic                        load, last;
  uds_pkg::unit_t              cur;

  assign cur     = head_i.units[idx_q];
  assign last    = (({1'b0, idx_q} + 3'd1) == head_i.num_units);
  assign load    = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + uds_pkg::CountBits'(1);

  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (load) begin
      out_valid_d            = 1'b1;
      out_d.code_point       = cur.code_point;
      out_d.unit_length      = cur.unit_length;
      out_d.is_error         = cur.is_error;
      out_d.unit_count       = 32'(cnt_inc);
      out_d.last_of_run      = last;
      out_d.text_done        = last & head_i.end_of_text;
      idx_d                  = last ? 2'd0 : idx_q + 2'd1;
      cnt_d                  = (last && head_i.end_of_text) ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign pop_o       = load & last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/utf8_stream_decoder_core.sv */
// top level of the strict utf-8 stream decoder
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | one text byte plus end-of-text flag
//  out     | source    | out_valid_o / out_stall_i| one unit: scalar or error byte, count
//
// a byte is taken every cycle while the two-entry job queue has room
// each byte yields zero to four units; the emitter sends one unit per cycle unless the output is stalled,
// so a byte's units leave one after another and hold the output side until the last is sent
// the job enters the queue at the accepting edge, and the out register then loads its
// units from the queue head
// reset clears the held-sequence count, the queue, the unit counter and out valid
// out stall backs up through the queue into in_stall_o only once the queue fills
module utf8_stream_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uds_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uds_pkg::out_beat_t out_data_o
);

  // front end to queue
  logic          job_valid;
  uds_pkg::job_t job;
  logic          q_full;

  // queue to back end
  logic          head_valid;
  uds_pkg::job_t head;
  logic          pop;

  // classifies bytes, holds the open sequence, assembles and checks scalars
  uds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_full_i  (q_full)
  );

  // decouples byte intake from unit emission
  uds_job_fifo u_job_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_valid),
    .push_data_i  (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // serializes units, keeps the saturating per-text count
  uds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
